/* hw/rtl/hist1d_pkg.sv */
// hist1d_pkg: shared types, codes and sizes for the 1-D histogram unit.
// No dependencies; imported by every hist1d module.
package hist1d_pkg;

    localparam int MAX_CHANNEL_BITS = 12;
    localparam int DEPTH            = 1 << MAX_CHANNEL_BITS;
    localparam int ADDR_W           = MAX_CHANNEL_BITS;
    localparam int LIM_W            = MAX_CHANNEL_BITS + 1;
    localparam int CNT_W            = 16;

    // opcodes
    localparam logic [1:0] OP_INC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHANNEL_BITS = 1'b0;
    localparam logic CFG_SCALE_DIFF   = 1'b1;

    // what the back end has to do with a classified item
    typedef enum logic [1:0] {
        K_NONE,
        K_INC,
        K_READ,
        K_WRITE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  wval;
        logic [1:0]        status;
    } entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

/* hw/rtl/histogram_1d_word_channels_unit.sv */
// histogram_1d_word_channels_unit: top level of the 1-D histogram unit.
// Depends on hist1d_pkg, hist1d_front, hist1d_queue, hist1d_back.
//
//  channel   handshake                 payload
//  -------   -----------------------   -----------------------------------------
//  config    cfg_valid / cfg_ready     cfg_index (0 channel_bits, 1 scale diff),
//                                      cfg_data
//  item in   start, taken if !busy     opcode, event_value, value_valid,
//                                      channel_index, write_value
//  result    done, one-cycle strobe    read_value, status
//
// In the back end each item takes a memory read step, then a write/result
// step, set by the single-port counter memory; with the back end idle, an
// accepted item goes through the queue, the read into rdata_reg and the
// execute state before done rises; no item is popped while another executes.
// After reset a clearing pass writes zero to all 4096 counters, one per
// cycle, holding busy high meanwhile; config writes are taken anytime.
// busy rises when the two-entry queue is full; the receiver cannot stall.
module histogram_1d_word_channels_unit (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    // item in
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] event_value,
    input  logic               value_valid,
    input  logic [15:0]        channel_index,
    input  logic [15:0]        write_value,
    // result
    output logic               done,
    output logic [15:0]        read_value,
    output logic [1:0]         status
);
    import hist1d_pkg::*;

    entry_t entry;
    entry_t head;
    logic   q_full;
    logic   q_empty;
    logic   pop;
    logic   clearing;
    logic   accept;

    // config writes are always accepted; the front applies them at once
    assign cfg_ready = 1'b1;

    // no items while the counter memory is being cleared
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    hist1d_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .event_value   (event_value),
        .value_valid   (value_valid),
        .channel_index (channel_index),
        .write_value   (write_value),
        .entry         (entry)
    );

    // classified items wait here until the back end is free
    hist1d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    hist1d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .read_value (read_value),
        .status     (status)
    );

endmodule

/* hw/rtl/hist1d_front.sv */
// hist1d_front: configuration registers and item classification.
// Depends on hist1d_pkg; feeds hist1d_queue.
module hist1d_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [5:0]            cfg_data,
    input  logic [1:0]            opcode,
    input  logic signed [31:0]    event_value,
    input  logic                  value_valid,
    input  logic [15:0]           channel_index,
    input  logic [15:0]           write_value,
    output hist1d_pkg::entry_t    entry
);
    import hist1d_pkg::*;

    logic [3:0]        channel_bits_reg;
    logic signed [5:0] scale_diff_reg;
    logic [3:0]        used_bits;
    logic [LIM_W-1:0]  limit;
    logic [31:0]       ev;
    logic [5:0]        lshift;
    logic [63:0]       wide;
    logic [31:0]       chan;
    logic              chan_ok;
    logic              idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_bits_reg <= 4'd12;
            scale_diff_reg   <= 6'sd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_BITS: channel_bits_reg <= cfg_data[3:0];
                CFG_SCALE_DIFF:   scale_diff_reg   <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // clamp channel_bits into 1..MAX
    always_comb
    begin
        priority if (channel_bits_reg == 4'd0)
            used_bits = 4'd1;
        else if (channel_bits_reg > 4'(MAX_CHANNEL_BITS))
            used_bits = 4'(MAX_CHANNEL_BITS);
        else
            used_bits = channel_bits_reg;
    end

    assign limit  = LIM_W'(1) << used_bits;
    assign ev     = $unsigned(event_value);
    // negative difference: left shift by its magnitude, 1..32
    assign lshift = 6'($unsigned(-scale_diff_reg));
    assign wide   = {32'd0, ev} << lshift;
    assign chan   = scale_diff_reg[5] ? wide[31:0] : (ev >> scale_diff_reg[4:0]);
    assign chan_ok = chan < 32'(limit);
    assign idx_ok  = 32'(channel_index) < 32'(limit);

    always_comb
    begin
        entry.kind   = K_NONE;
        entry.addr   = channel_index[ADDR_W-1:0];
        entry.wval   = write_value;
        entry.status = ST_DONE;
        unique case (opcode)
            OP_INC:
            begin
                entry.addr = chan[ADDR_W-1:0];
                if (!value_valid || ev[31] || !chan_ok)
                    entry.status = ST_DROP;
                else
                    entry.kind = K_INC;
            end
            OP_READ:
            begin
                if (idx_ok) entry.kind = K_READ;
                else        entry.status = ST_RANGE;
            end
            OP_WRITE:
            begin
                if (idx_ok) entry.kind = K_WRITE;
                else        entry.status = ST_RANGE;
            end
            default: ;  // unused opcode: no action, done
        endcase
    end

endmodule

/* hw/rtl/hist1d_queue.sv */
// hist1d_queue: two-entry FIFO of classified items between front and back.
// Depends on hist1d_pkg.
module hist1d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hist1d_pkg::entry_t push_entry,
    input  logic               pop,
    output hist1d_pkg::entry_t head,
    output logic               full,
    output logic               empty
);
    import hist1d_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/hist1d_back.sv */
// hist1d_back: counter memory, clearing pass, read-modify-write and results.
// Depends on hist1d_pkg; pops from hist1d_queue.
module hist1d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hist1d_pkg::entry_t head,
    input  logic               q_empty,
    output logic               pop,
    output logic               clearing,
    output logic               done,
    output logic [15:0]        read_value,
    output logic [1:0]         status
);
    import hist1d_pkg::*;

    logic [CNT_W-1:0]  mem [DEPTH];
    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    entry_t            cur_reg;
    logic [CNT_W-1:0]  rdata_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  read_value_reg;
    logic [1:0]        status_reg;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic              exec;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = BK_IDLE;
            BK_IDLE:  if (!q_empty) state_next = BK_EXEC;
            BK_EXEC:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        exec      = 1'b0;
        clearing  = 1'b0;
        mem_waddr = cur_reg.addr;
        mem_wdata = cur_reg.wval;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            BK_IDLE:
            begin
                pop    = !q_empty;
                mem_re = !q_empty;
            end
            BK_EXEC:
            begin
                exec   = 1'b1;
                mem_we = (cur_reg.kind == K_INC) || (cur_reg.kind == K_WRITE);
                if (cur_reg.kind == K_INC) mem_wdata = rdata_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= mem[head.addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop) cur_reg <= head;
        if (exec)
        begin
            read_value_reg <= (cur_reg.kind == K_READ) ? rdata_reg : '0;
            status_reg     <= cur_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (state_reg == BK_CLEAR) clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BK_EXEC))
        else $error("result strobe without a completed item");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("counter memory read and written in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EXEC) |=> (state_reg == BK_IDLE))
        else $error("execute state held longer than one cycle");

endmodule
